// ===== hw/rtl/msl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package msl_pkg;

  // field widths fixed by the segment record
  localparam int KIND_BITS    = 2;
  localparam int SEG_LEN_BITS = 24;
  localparam int MIN_BITS     = 10;
  localparam int MIN_SQ_BITS  = 2 * MIN_BITS;

  // chord differences saturate here; any saturated axis already beats the cap
  localparam int DIFF_BITS  = 11;
  localparam int SQ_BITS    = 2 * DIFF_BITS;
  localparam int CHORD_BITS = SQ_BITS + 1;

  // results one segment can cause
  localparam int NUM_SLOTS = 3;
  localparam int CNT_BITS  = $clog2(NUM_SLOTS + 1);
  localparam int IDX_BITS  = $clog2(NUM_SLOTS);

  // register file
  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS    = 3;
  localparam int REG_IDX_BITS  = PADDR_BITS - 2;
  localparam logic [REG_IDX_BITS-1:0] REG_MIN_LENGTH = '0;

  localparam logic [MIN_BITS-1:0]    MIN_LEN_RST = MIN_BITS'(500);
  localparam logic [MIN_BITS-1:0]    LEN_CAP     = MIN_BITS'(1000);
  localparam logic [MIN_SQ_BITS-1:0] MIN_SQ_RST  = MIN_SQ_BITS'(500 * 500);

  localparam int COORD_BITS_DEF = 24;
  localparam int TAG_BITS_DEF   = 22;

  // segment kinds
  localparam logic [KIND_BITS-1:0] KIND_LINEAR = 2'd0;
  localparam logic [KIND_BITS-1:0] KIND_OTHER  = 2'd1;
  localparam logic [KIND_BITS-1:0] KIND_END    = 2'd2;

  // per-bundle control: result count plus the narrow fields of each slot
  typedef struct packed {
    logic [CNT_BITS-1:0]                 cnt;
    logic [NUM_SLOTS-1:0][KIND_BITS-1:0] kind;
    logic [NUM_SLOTS-1:0]                joined;
  } msl_bctl_t;

endpackage

`default_nettype wire

// ===== hw/rtl/msl_chord.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msl_chord import msl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic        [CHORD_BITS-1:0] chord_sq_o
);

  logic signed [COORD_BITS:0] dx, dy;
  logic        [COORD_BITS:0] adx, ady;
  logic        [DIFF_BITS-1:0] cx, cy;
  logic        [SQ_BITS-1:0]   sqx, sqy;

  assign dx  = {ax_i[COORD_BITS-1], ax_i} - {bx_i[COORD_BITS-1], bx_i};
  assign dy  = {ay_i[COORD_BITS-1], ay_i} - {by_i[COORD_BITS-1], by_i};
  assign adx = dx[COORD_BITS] ? (COORD_BITS+1)'(0) - dx : dx;
  assign ady = dy[COORD_BITS] ? (COORD_BITS+1)'(0) - dy : dy;

  // saturate magnitudes
  assign cx = (|adx[COORD_BITS:DIFF_BITS]) ? '1 : adx[DIFF_BITS-1:0];
  assign cy = (|ady[COORD_BITS:DIFF_BITS]) ? '1 : ady[DIFF_BITS-1:0];

  assign sqx = SQ_BITS'(cx) * SQ_BITS'(cx);
  assign sqy = SQ_BITS'(cy) * SQ_BITS'(cy);
  assign chord_sq_o = CHORD_BITS'(sqx) + CHORD_BITS'(sqy);

endmodule

`default_nettype wire

// ===== hw/rtl/msl_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msl_core import msl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  logic        [KIND_BITS-1:0]  kind_i,
  input  logic        [TAG_BITS-1:0]   tag_i,
  input  logic signed [COORD_BITS-1:0] sx_i,
  input  logic signed [COORD_BITS-1:0] sy_i,
  input  logic signed [COORD_BITS-1:0] ex_i,
  input  logic signed [COORD_BITS-1:0] ey_i,
  input  logic        [SEG_LEN_BITS-1:0] seg_len_i,
  input  logic        [MIN_BITS-1:0]   min_len_i,
  input  logic        [MIN_SQ_BITS-1:0] min_sq_i,
  output msl_bctl_t                    ctl_o,
  output logic        [TAG_BITS-1:0]   res_tag_o [NUM_SLOTS],
  output logic signed [COORD_BITS-1:0] res_x_o   [NUM_SLOTS],
  output logic signed [COORD_BITS-1:0] res_y_o   [NUM_SLOTS]
);

  typedef enum logic [1:0] {PH_IDLE, PH_OPEN, PH_CLOSED, PH_AHEAD} phase_e;

  phase_e phase_q, phase_d;

  logic        [TAG_BITS-1:0]   g_tag_q, g_tag_d, a_tag_q, a_tag_d;
  logic signed [COORD_BITS-1:0] g_sx_q, g_sx_d, g_sy_q, g_sy_d, g_ex_q, g_ex_d, g_ey_q, g_ey_d;
  logic signed [COORD_BITS-1:0] a_sx_q, a_sx_d, a_sy_q, a_sy_d, a_ex_q, a_ex_d, a_ey_q, a_ey_d;
  logic g_j_q, g_j_d, a_j_q, a_j_d, a_nz_q, a_nz_d;

  logic                  lin, len_hit, c_hit, c_nz;
  logic [CHORD_BITS-1:0] chord_sq;

  msl_chord #(.COORD_BITS(COORD_BITS)) u_chord (
    .ax_i       ((phase_q == PH_AHEAD) ? a_sx_q : g_sx_q),
    .ay_i       ((phase_q == PH_AHEAD) ? a_sy_q : g_sy_q),
    .bx_i       (ex_i),
    .by_i       (ey_i),
    .chord_sq_o (chord_sq)
  );

  assign lin     = (kind_i == KIND_LINEAR);
  assign len_hit = (seg_len_i >= SEG_LEN_BITS'(min_len_i));
  assign c_hit   = (chord_sq >= CHORD_BITS'(min_sq_i));
  assign c_nz    = (chord_sq != '0);

  // next state
  always_comb begin
    phase_d = phase_q;
    g_tag_d = g_tag_q; g_sx_d = g_sx_q; g_sy_d = g_sy_q;
    g_ex_d  = g_ex_q;  g_ey_d = g_ey_q; g_j_d  = g_j_q;
    a_tag_d = a_tag_q; a_sx_d = a_sx_q; a_sy_d = a_sy_q;
    a_ex_d  = a_ex_q;  a_ey_d = a_ey_q; a_j_d  = a_j_q;
    a_nz_d  = a_nz_q;
    if (!lin) begin
      phase_d = PH_IDLE;
    end else begin
      case (phase_q)
        PH_IDLE: begin
          g_tag_d = tag_i; g_sx_d = sx_i; g_sy_d = sy_i;
          g_ex_d  = ex_i;  g_ey_d = ey_i; g_j_d  = 1'b0;
          phase_d = len_hit ? PH_CLOSED : PH_OPEN;
        end
        PH_OPEN: begin
          g_ex_d = ex_i; g_ey_d = ey_i; g_j_d = 1'b1;
          if (c_hit) phase_d = PH_CLOSED;
        end
        PH_CLOSED: begin
          if (len_hit) begin
            g_tag_d = tag_i; g_sx_d = sx_i; g_sy_d = sy_i;
            g_ex_d  = ex_i;  g_ey_d = ey_i; g_j_d  = 1'b0;
          end else begin
            a_tag_d = tag_i; a_sx_d = sx_i; a_sy_d = sy_i;
            a_ex_d  = ex_i;  a_ey_d = ey_i; a_j_d  = 1'b0;
            a_nz_d  = (seg_len_i != '0);
            phase_d = PH_AHEAD;
          end
        end
        PH_AHEAD: begin
          a_ex_d = ex_i; a_ey_d = ey_i; a_j_d = 1'b1; a_nz_d = c_nz;
          if (c_hit) begin
            // watched run closes and takes over as the group
            g_tag_d = a_tag_q; g_sx_d = a_sx_q; g_sy_d = a_sy_q;
            g_ex_d  = ex_i;    g_ey_d = ey_i;   g_j_d  = 1'b1;
            phase_d = PH_CLOSED;
          end
        end
        default: phase_d = PH_IDLE;
      endcase
    end
  end

  // result bundle
  always_comb begin
    ctl_o.cnt = '0;
    // slot 0: closed group by default
    res_tag_o[0]     = g_tag_q;
    res_x_o[0]       = g_ex_q;
    res_y_o[0]       = g_ey_q;
    ctl_o.kind[0]    = KIND_LINEAR;
    ctl_o.joined[0]  = g_j_q;
    // slot 1: watched run or the item
    res_tag_o[1]     = tag_i;
    res_x_o[1]       = ex_i;
    res_y_o[1]       = ey_i;
    ctl_o.kind[1]    = kind_i;
    ctl_o.joined[1]  = 1'b0;
    // slot 2: always the item
    res_tag_o[2]     = tag_i;
    res_x_o[2]       = ex_i;
    res_y_o[2]       = ey_i;
    ctl_o.kind[2]    = kind_i;
    ctl_o.joined[2]  = 1'b0;
    if (lin) begin
      if ((phase_q == PH_CLOSED && len_hit) || (phase_q == PH_AHEAD && c_hit)) begin
        ctl_o.cnt = CNT_BITS'(1);
      end
    end else begin
      case (phase_q)
        PH_IDLE: begin
          ctl_o.cnt       = CNT_BITS'(1);
          res_tag_o[0]    = tag_i;
          res_x_o[0]      = ex_i;
          res_y_o[0]      = ey_i;
          ctl_o.kind[0]   = kind_i;
          ctl_o.joined[0] = 1'b0;
        end
        PH_OPEN, PH_CLOSED: ctl_o.cnt = CNT_BITS'(2);
        PH_AHEAD: begin
          if (a_nz_q) begin
            // watched run absorbed into the group
            ctl_o.cnt       = CNT_BITS'(2);
            res_x_o[0]      = a_ex_q;
            res_y_o[0]      = a_ey_q;
            ctl_o.joined[0] = 1'b1;
          end else begin
            ctl_o.cnt       = CNT_BITS'(3);
            res_tag_o[1]    = a_tag_q;
            res_x_o[1]      = a_ex_q;
            res_y_o[1]      = a_ey_q;
            ctl_o.kind[1]   = KIND_LINEAR;
            ctl_o.joined[1] = a_j_q;
          end
        end
        default: ctl_o.cnt = '0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      g_j_q   <= 1'b0;
      a_j_q   <= 1'b0;
      a_nz_q  <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      g_j_q   <= g_j_d;
      a_j_q   <= a_j_d;
      a_nz_q  <= a_nz_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i) begin
      g_tag_q <= g_tag_d; g_sx_q <= g_sx_d; g_sy_q <= g_sy_d;
      g_ex_q  <= g_ex_d;  g_ey_q <= g_ey_d;
      a_tag_q <= a_tag_d; a_sx_q <= a_sx_d; a_sy_q <= a_sy_d;
      a_ex_q  <= a_ex_d;  a_ey_q <= a_ey_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/msl_outq.sv =====
`timescale 1ns / 1ps
`default_nettype none

module msl_outq import msl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         load_i,
  input  msl_bctl_t                    ctl_i,
  input  logic        [TAG_BITS-1:0]   tag_i [NUM_SLOTS],
  input  logic signed [COORD_BITS-1:0] x_i   [NUM_SLOTS],
  input  logic signed [COORD_BITS-1:0] y_i   [NUM_SLOTS],
  output logic                         load_ok_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic        [TAG_BITS-1:0]   out_tag_o,
  output logic        [KIND_BITS-1:0]  out_kind_o,
  output logic signed [COORD_BITS-1:0] out_x_o,
  output logic signed [COORD_BITS-1:0] out_y_o,
  output logic                         out_joined_o,
  output logic                         out_last_o
);

  msl_bctl_t                    ctl_q;
  logic                         vld_q;
  logic        [IDX_BITS-1:0]   idx_q;
  logic        [TAG_BITS-1:0]   tag_q [NUM_SLOTS];
  logic signed [COORD_BITS-1:0] x_q   [NUM_SLOTS];
  logic signed [COORD_BITS-1:0] y_q   [NUM_SLOTS];
  logic                         take, last;

  assign last      = (CNT_BITS'(idx_q) == ctl_q.cnt - CNT_BITS'(1));
  assign take      = vld_q && out_ready_i;
  assign load_ok_o = !vld_q || (take && last);

  assign out_valid_o  = vld_q;
  assign out_tag_o    = tag_q[idx_q];
  assign out_kind_o   = ctl_q.kind[idx_q];
  assign out_x_o      = x_q[idx_q];
  assign out_y_o      = y_q[idx_q];
  assign out_joined_o = ctl_q.joined[idx_q];
  assign out_last_o   = last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
      ctl_q <= '0;
    end else if (load_i) begin
      vld_q <= 1'b1;
      idx_q <= '0;
      ctl_q <= ctl_i;
    end else if (take && last) begin
      vld_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + IDX_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      tag_q <= tag_i;
      x_q   <= x_i;
      y_q   <= y_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/merge_short_line_segments_top.sv =====
// channel  | direction | handshake                 | payload
// ---------+-----------+---------------------------+-------------------------------------
// segment  | in        | in_valid_i / in_ready_o   | kind, tag, start/end x/y, seg_length
// result   | out       | out_valid_o / out_ready_i | tag, kind, end x/y, joined, last
// config   | in        | psel/penable/pwrite       | min_length at byte address 0
//
// one segment per cycle while its results fit in the result register: the segment register feeds
// the merge step, whose two small squarings and compares are combinational
// a segment yields zero to three results; the result register hands them out one per cycle
// while out_ready_i is high, and the next segment with results waits until the last is taken
// first result of a segment passes through the segment register and then the result register
// reset is asynchronous and active low; no group is pending afterwards
`timescale 1ns / 1ps
`default_nettype none

module merge_short_line_segments_top import msl_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int TAG_BITS   = TAG_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // segment channel
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic        [KIND_BITS-1:0]    kind_i,
  input  logic        [TAG_BITS-1:0]     tag_i,
  input  logic signed [COORD_BITS-1:0]   start_x_i,
  input  logic signed [COORD_BITS-1:0]   start_y_i,
  input  logic signed [COORD_BITS-1:0]   end_x_i,
  input  logic signed [COORD_BITS-1:0]   end_y_i,
  input  logic        [SEG_LEN_BITS-1:0] seg_length_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic        [TAG_BITS-1:0]     out_tag_o,
  output logic        [KIND_BITS-1:0]    out_kind_o,
  output logic signed [COORD_BITS-1:0]   out_end_x_o,
  output logic signed [COORD_BITS-1:0]   out_end_y_o,
  output logic                           joined_o,
  output logic                           last_of_run_o,
  // register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic        [PADDR_BITS-1:0]   paddr,
  input  logic        [APB_DATA_BITS-1:0] pwdata,
  output logic        [APB_DATA_BITS-1:0] prdata,
  output logic                           pready
);

  // config registers: raw value for readback, capped value and its square
  logic [MIN_BITS-1:0]    min_len_q, min_cap_q, wr_cap;
  logic [MIN_SQ_BITS-1:0] min_sq_q;
  logic                   cfg_wr;
  logic [REG_IDX_BITS-1:0] reg_idx;

  // segment register
  logic                         in_vld_q;
  logic        [KIND_BITS-1:0]  kind_q;
  logic        [TAG_BITS-1:0]   tag_q;
  logic signed [COORD_BITS-1:0] sx_q, sy_q, ex_q, ey_q;
  logic        [SEG_LEN_BITS-1:0] len_q;

  // merge step to result register
  msl_bctl_t                    res_ctl;
  logic        [TAG_BITS-1:0]   res_tag [NUM_SLOTS];
  logic signed [COORD_BITS-1:0] res_x   [NUM_SLOTS];
  logic signed [COORD_BITS-1:0] res_y   [NUM_SLOTS];
  logic                         load_ok, advance, load;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[PADDR_BITS-1:2];
  assign cfg_wr  = psel && penable && pwrite && (reg_idx == REG_MIN_LENGTH);
  assign wr_cap  = (pwdata[MIN_BITS-1:0] > LEN_CAP) ? LEN_CAP : pwdata[MIN_BITS-1:0];
  assign prdata  = (reg_idx == REG_MIN_LENGTH) ? APB_DATA_BITS'(min_len_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MIN_LEN_RST;
      min_cap_q <= MIN_LEN_RST;
      min_sq_q  <= MIN_SQ_RST;
    end else if (cfg_wr) begin
      min_len_q <= pwdata[MIN_BITS-1:0];
      min_cap_q <= wr_cap;
      min_sq_q  <= MIN_SQ_BITS'(wr_cap) * MIN_SQ_BITS'(wr_cap);
    end
  end

  // the step runs when its results fit; segments without results never wait
  assign advance    = in_vld_q && ((res_ctl.cnt == '0) || load_ok);
  assign load       = advance && (res_ctl.cnt != '0);
  assign in_ready_o = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      kind_q <= kind_i;
      tag_q  <= tag_i;
      sx_q   <= start_x_i;
      sy_q   <= start_y_i;
      ex_q   <= end_x_i;
      ey_q   <= end_y_i;
      len_q  <= seg_length_i;
    end
  end

  // grouping state and result selection
  msl_core #(.COORD_BITS(COORD_BITS), .TAG_BITS(TAG_BITS)) u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .kind_i    (kind_q),
    .tag_i     (tag_q),
    .sx_i      (sx_q),
    .sy_i      (sy_q),
    .ex_i      (ex_q),
    .ey_i      (ey_q),
    .seg_len_i (len_q),
    .min_len_i (min_cap_q),
    .min_sq_i  (min_sq_q),
    .ctl_o     (res_ctl),
    .res_tag_o (res_tag),
    .res_x_o   (res_x),
    .res_y_o   (res_y)
  );

  // result register, drained one result per transaction
  msl_outq #(.COORD_BITS(COORD_BITS), .TAG_BITS(TAG_BITS)) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (load),
    .ctl_i        (res_ctl),
    .tag_i        (res_tag),
    .x_i          (res_x),
    .y_i          (res_y),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_tag_o    (out_tag_o),
    .out_kind_o   (out_kind_o),
    .out_x_o      (out_end_x_o),
    .out_y_o      (out_end_y_o),
    .out_joined_o (joined_o),
    .out_last_o   (last_of_run_o)
  );

`ifndef ASSERT_OFF
  // results are only loaded when the result register is free or its last result is being taken
  a_load_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> load_ok) else $error("result bundle overwrote pending results");

  // a non-linear segment always yields at least its own result
  a_cmd_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && kind_q != KIND_LINEAR) |-> res_ctl.cnt != '0)
    else $error("command segment produced no result");

  // a full segment register that cannot step keeps the input stalled
  a_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |-> !in_ready_o) else $error("input taken while stalled");

  // a segment that steps with results leaves the result register valid
  a_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> out_valid_o) else $error("loaded results not presented");
`endif

endmodule

`default_nettype wire

// ===== dv/merge_short_line_segments_top_tb.sv =====
`timescale 1ns / 1ps

module merge_short_line_segments_top_tb;
  import msl_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int TW = TAG_BITS_DEF;

  // a two-bit kind of three is legal on the wire and passes through like an other command
  localparam logic [KIND_BITS-1:0] KIND_RESERVED = 2'd3;

  localparam logic [PADDR_BITS-1:0] ADDR_MIN_LENGTH = {REG_MIN_LENGTH, 2'b00};

  localparam int RESET_CYCLES    = 12;
  localparam int CYCLE_LIMIT     = 400000;
  // leave margin for empty steps after the owed results are collected
  localparam int DRAIN_CYCLES    = 8;
  localparam int NUM_CFG_PHASES  = 6;
  localparam int ITEMS_PER_PHASE = 16;
  localparam int NUM_DIRECTED    = 24;

  // group tracking states of the merger
  typedef enum logic [1:0] {
    PH_IDLE,    // no group pending
    PH_OPEN,    // group open, chord below minimum
    PH_CLOSED,  // group closed, nothing watched
    PH_WATCH    // group closed, next linear run watched ahead
  } merge_phase_e;

  typedef struct packed {
    logic        [KIND_BITS-1:0]    kind;
    logic        [TW-1:0]           tag;
    logic signed [CW-1:0]           sx;
    logic signed [CW-1:0]           sy;
    logic signed [CW-1:0]           ex;
    logic signed [CW-1:0]           ey;
    logic        [SEG_LEN_BITS-1:0] len;
  } seg_t;

  // one kept segment as it should leave the block; plain bit patterns
  typedef struct packed {
    logic [TW-1:0]        tag;
    logic [KIND_BITS-1:0] kind;
    logic [CW-1:0]        ex;
    logic [CW-1:0]        ey;
    logic                 joined;
    logic                 last;
  } kept_t;

  // directed row; thru marks a lone pass-through whose result is typed in here
  typedef struct packed {
    logic                           thru;
    logic        [KIND_BITS-1:0]    kind;
    logic        [TW-1:0]           tag;
    logic signed [CW-1:0]           sx;
    logic signed [CW-1:0]           sy;
    logic signed [CW-1:0]           ex;
    logic signed [CW-1:0]           ey;
    logic        [SEG_LEN_BITS-1:0] len;
  } dir_row_t;

  // clock, reset and all block inputs start at known values
  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                           in_valid_i   = 1'b0;
  logic                           in_ready_o;
  logic        [KIND_BITS-1:0]    kind_i       = '0;
  logic        [TW-1:0]           tag_i        = '0;
  logic signed [CW-1:0]           start_x_i    = '0;
  logic signed [CW-1:0]           start_y_i    = '0;
  logic signed [CW-1:0]           end_x_i      = '0;
  logic signed [CW-1:0]           end_y_i      = '0;
  logic        [SEG_LEN_BITS-1:0] seg_length_i = '0;

  logic                           out_valid_o;
  logic                           out_ready_i  = 1'b0;
  logic        [TW-1:0]           out_tag_o;
  logic        [KIND_BITS-1:0]    out_kind_o;
  logic signed [CW-1:0]           out_end_x_o;
  logic signed [CW-1:0]           out_end_y_o;
  logic                           joined_o;
  logic                           last_of_run_o;

  logic                           psel         = 1'b0;
  logic                           penable      = 1'b0;
  logic                           pwrite       = 1'b0;
  logic        [PADDR_BITS-1:0]   paddr        = '0;
  logic        [APB_DATA_BITS-1:0] pwdata      = '0;
  logic        [APB_DATA_BITS-1:0] prdata;
  logic                           pready;

  merge_short_line_segments_top #(
    .COORD_BITS (CW),
    .TAG_BITS   (TW)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .kind_i        (kind_i),
    .tag_i         (tag_i),
    .start_x_i     (start_x_i),
    .start_y_i     (start_y_i),
    .end_x_i       (end_x_i),
    .end_y_i       (end_y_i),
    .seg_length_i  (seg_length_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_tag_o     (out_tag_o),
    .out_kind_o    (out_kind_o),
    .out_end_x_o   (out_end_x_o),
    .out_end_y_o   (out_end_y_o),
    .joined_o      (joined_o),
    .last_of_run_o (last_of_run_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // 20 ns period
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // merge predictor: own copy of the register and of the group records
  // ---------------------------------------------------------------------------
  logic        [MIN_BITS-1:0] min_len_cfg = MIN_LEN_RST;
  merge_phase_e               grp_phase   = PH_IDLE;

  // closed or open group
  logic        [TW-1:0] grp_tag;
  logic signed [CW-1:0] grp_sx, grp_sy, grp_ex, grp_ey;
  logic                 grp_joined = 1'b0;

  // linear run watched ahead of a closed group
  logic        [TW-1:0] ahd_tag;
  logic signed [CW-1:0] ahd_sx, ahd_sy, ahd_ex, ahd_ey;
  logic                 ahd_joined  = 1'b0;
  logic                 ahd_nonzero = 1'b0;

  kept_t step_kept[$];    // results of the segment just predicted
  kept_t kept_due[$];     // results still owed by the block, oldest first

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int fail_cnt = 0;
  int unsigned cycle_cnt = 0;

  // generator cursor: well-formed runs chain end to start
  logic signed [CW-1:0] cur_x = '0, cur_y = '0;
  logic signed [CW-1:0] prev_sx = '0, prev_sy = '0;

  function automatic longint unsigned chord_sq(logic signed [CW-1:0] ax,
                                               logic signed [CW-1:0] ay,
                                               logic signed [CW-1:0] bx,
                                               logic signed [CW-1:0] by);
    longint dx, dy;
    dx = longint'(ax) - longint'(bx);
    dy = longint'(ay) - longint'(by);
    // no clamp needed: 64 bits hold the full squared distance
    return longint'(dx * dx + dy * dy);
  endfunction

  function automatic void keep(logic [TW-1:0] tag, logic [KIND_BITS-1:0] kind,
                               logic signed [CW-1:0] ex, logic signed [CW-1:0] ey,
                               logic joined);
    kept_t k;
    k.tag    = tag;
    k.kind   = kind;
    k.ex     = ex;
    k.ey     = ey;
    k.joined = joined;
    k.last   = 1'b0;
    step_kept.push_back(k);
  endfunction

  function automatic void merge_step(seg_t s);
    longint unsigned lim, lim_sq, c;
    step_kept.delete();
    // register values above the cap behave as the cap
    lim    = (min_len_cfg > LEN_CAP) ? LEN_CAP : min_len_cfg;
    lim_sq = lim * lim;
    if (s.kind == KIND_LINEAR) begin
      case (grp_phase)
        PH_IDLE: begin
          grp_tag = s.tag; grp_sx = s.sx; grp_sy = s.sy;
          grp_ex = s.ex; grp_ey = s.ey; grp_joined = 1'b0;
          grp_phase = (s.len >= lim) ? PH_CLOSED : PH_OPEN;
        end
        PH_OPEN: begin
          c = chord_sq(grp_sx, grp_sy, s.ex, s.ey);
          grp_ex = s.ex; grp_ey = s.ey; grp_joined = 1'b1;
          if (c >= lim_sq) grp_phase = PH_CLOSED;
        end
        PH_CLOSED: begin
          if (s.len >= lim) begin
            keep(grp_tag, KIND_LINEAR, grp_ex, grp_ey, grp_joined);
            grp_tag = s.tag; grp_sx = s.sx; grp_sy = s.sy;
            grp_ex = s.ex; grp_ey = s.ey; grp_joined = 1'b0;
          end else begin
            ahd_tag = s.tag; ahd_sx = s.sx; ahd_sy = s.sy;
            ahd_ex = s.ex; ahd_ey = s.ey; ahd_joined = 1'b0;
            ahd_nonzero = (s.len != 0);
            grp_phase = PH_WATCH;
          end
        end
        default: begin
          c = chord_sq(ahd_sx, ahd_sy, s.ex, s.ey);
          ahd_ex = s.ex; ahd_ey = s.ey; ahd_joined = 1'b1;
          ahd_nonzero = (c != 0);
          // watched run long enough on its own: it becomes the closed group
          if (c >= lim_sq) begin
            keep(grp_tag, KIND_LINEAR, grp_ex, grp_ey, grp_joined);
            grp_tag = ahd_tag; grp_sx = ahd_sx; grp_sy = ahd_sy;
            grp_ex = ahd_ex; grp_ey = ahd_ey; grp_joined = ahd_joined;
            grp_phase = PH_CLOSED;
          end
        end
      endcase
    end else begin
      case (grp_phase)
        PH_OPEN, PH_CLOSED: keep(grp_tag, KIND_LINEAR, grp_ex, grp_ey, grp_joined);
        PH_WATCH: begin
          if (ahd_nonzero) begin
            // short watched run is absorbed into the group before it
            keep(grp_tag, KIND_LINEAR, ahd_ex, ahd_ey, 1'b1);
          end else begin
            keep(grp_tag, KIND_LINEAR, grp_ex, grp_ey, grp_joined);
            keep(ahd_tag, KIND_LINEAR, ahd_ex, ahd_ey, ahd_joined);
          end
        end
        default: ;
      endcase
      keep(s.tag, s.kind, s.ex, s.ey, 1'b0);
      grp_phase = PH_IDLE;
    end
    if (step_kept.size() > 0) step_kept[step_kept.size() - 1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // segment channel driver
  // ---------------------------------------------------------------------------
  task automatic send_segment(input seg_t s, input logic thru);
    kept_t k;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    kind_i       <= s.kind;
    tag_i        <= s.tag;
    start_x_i    <= s.sx;
    start_y_i    <= s.sy;
    end_x_i      <= s.ex;
    end_y_i      <= s.ey;
    seg_length_i <= s.len;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction taken at this edge; its results follow through the segment and result registers
    merge_step(s);
    if (thru) begin
      k.tag    = s.tag;
      k.kind   = s.kind;
      k.ex     = s.ex;
      k.ey     = s.ey;
      k.joined = 1'b0;
      k.last   = 1'b1;
      kept_due.push_back(k);
    end else begin
      foreach (step_kept[i]) kept_due.push_back(step_kept[i]);
    end
  endtask

  // stop sending, collect every owed result, then let empty steps settle
  task automatic drain_block();
    in_valid_i <= 1'b0;
    while (kept_due.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // setup then access phase; the register takes the value at the access edge
  task automatic write_min_length(input logic [MIN_BITS-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_MIN_LENGTH;
    pwdata  <= {(APB_DATA_BITS - MIN_BITS)'($urandom), val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    min_len_cfg = val;
  endtask

  // ---------------------------------------------------------------------------
  // random segments: mostly chained linear runs sized around the minimum,
  // closed by other commands, program ends or the reserved kind, plus some full-range noise
  // ---------------------------------------------------------------------------
  task automatic make_segment(output seg_t s);
    int lim, m, dx, dy, pick, shape;
    longint d2;
    lim   = (min_len_cfg > LEN_CAP) ? int'(LEN_CAP) : int'(min_len_cfg);
    if (lim < 4) lim = 4;
    pick  = $urandom_range(99);
    s.tag = TW'($urandom);
    if (pick < 12) begin
      // noise: every bit of every field free
      s.kind = KIND_BITS'($urandom_range(3));
      s.sx   = CW'($urandom);
      s.sy   = CW'($urandom);
      s.ex   = CW'($urandom);
      s.ey   = CW'($urandom);
      s.len  = SEG_LEN_BITS'($urandom);
    end else if (pick < 24) begin
      // run terminator
      shape  = $urandom_range(99);
      s.kind = (shape < 45) ? KIND_OTHER : (shape < 90) ? KIND_END : KIND_RESERVED;
      s.sx   = cur_x;
      s.sy   = cur_y;
      s.ex   = CW'(int'(cur_x) + $urandom_range(200) - 100);
      s.ey   = CW'(int'(cur_y) + $urandom_range(200) - 100);
      s.len  = SEG_LEN_BITS'($urandom_range(150));
    end else begin
      s.kind = KIND_LINEAR;
      shape  = $urandom_range(99);
      if (shape < 8) begin
        dx = 0;
        dy = 0;
      end else if (shape < 16) begin
        // step back to the previous start: zero chord for a one-segment run
        dx = int'(prev_sx) - int'(cur_x);
        dy = int'(prev_sy) - int'(cur_y);
      end else begin
        if (shape < 60)      m = $urandom_range(lim / 3);
        else if (shape < 85) m = $urandom_range(lim, lim / 2);
        else                 m = $urandom_range(2 * lim, lim);
        dx = $urandom_range(2 * m) - m;
        dy = $urandom_range(2 * m) - m;
        if ($urandom_range(1)) dx = ($urandom_range(1)) ? m : -m;
      end
      s.sx = cur_x;
      s.sy = cur_y;
      s.ex = CW'(int'(cur_x) + dx);
      s.ey = CW'(int'(cur_y) + dy);
      d2   = longint'(dx) * dx + longint'(dy) * dy;
      d2   = longint'($sqrt(real'(d2)));
      if (d2 > 64'hFFFFFF) d2 = 64'hFFFFFF;
      s.len = ($urandom_range(9) == 0) ? SEG_LEN_BITS'($urandom_range(2 * lim))
                                       : SEG_LEN_BITS'(d2);
    end
    prev_sx = s.sx;
    prev_sy = s.sy;
    cur_x   = s.ex;
    cur_y   = s.ey;
  endtask

  // directed rows, minimum at its reset value of 500
  dir_row_t directed_rows [NUM_DIRECTED] = '{
    // pass-through after reset, field extremes, the reserved kind
    '{1'b1, KIND_OTHER,    22'd0,        24'sd0,     24'sd0,     24'sd0,     24'sd0,     24'd0},
    '{1'b1, KIND_END,      22'h3FFFFF,   24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'h800000, 24'hFFFFFF},
    '{1'b1, KIND_RESERVED, 22'h155555,   24'h800000, 24'h7FFFFF, 24'h800000, 24'h7FFFFF, 24'd0},
    // long segment closes at once, next long one flushes it
    '{1'b0, KIND_LINEAR,   22'd10,       24'sd0,     24'sd0,     24'sd600,   24'sd0,     24'd600},
    '{1'b0, KIND_LINEAR,   22'd11,       24'sd600,   24'sd0,     24'sd1200,  24'sd0,     24'd600},
    // short run watched ahead and absorbed at an other command
    '{1'b0, KIND_LINEAR,   22'd12,       24'sd1200,  24'sd0,     24'sd1300,  24'sd0,     24'd100},
    '{1'b0, KIND_LINEAR,   22'd13,       24'sd1300,  24'sd0,     24'sd1400,  24'sd0,     24'd100},
    '{1'b0, KIND_OTHER,    22'd14,       24'sd1400,  24'sd0,     24'sd1400,  24'sd50,    24'd50},
    // open group grows until its chord equals the minimum exactly
    '{1'b0, KIND_LINEAR,   22'd20,       24'sd0,     24'sd0,     24'sd100,   24'sd100,   24'd141},
    '{1'b0, KIND_LINEAR,   22'd21,       24'sd100,   24'sd100,   24'sd200,   24'sd200,   24'd141},
    '{1'b0, KIND_LINEAR,   22'd22,       24'sd200,   24'sd200,   24'sd400,   24'sd300,   24'd223},
    // zero-length watched run at a program end: three results
    '{1'b0, KIND_LINEAR,   22'd23,       24'sd400,   24'sd300,   24'sd400,   24'sd300,   24'd0},
    '{1'b0, KIND_END,      22'd24,       24'sd400,   24'sd300,   24'sd400,   24'sd300,   24'd0},
    // watched run reaches the minimum and becomes the closed group
    '{1'b0, KIND_LINEAR,   22'd30,       -24'sd1000, -24'sd1000, -24'sd300,  -24'sd1000, 24'd700},
    '{1'b0, KIND_LINEAR,   22'd31,       -24'sd300,  -24'sd1000, -24'sd100,  -24'sd1000, 24'd200},
    '{1'b0, KIND_LINEAR,   22'd32,       -24'sd100,  -24'sd1000, 24'sd200,   -24'sd1000, 24'd300},
    // watched run wanders and returns to its start: zero chord
    '{1'b0, KIND_LINEAR,   22'd33,       24'sd200,   -24'sd1000, 24'sd250,   -24'sd1000, 24'd50},
    '{1'b0, KIND_LINEAR,   22'd34,       24'sd250,   -24'sd1000, 24'sd300,   -24'sd1000, 24'd50},
    '{1'b0, KIND_LINEAR,   22'd35,       24'sd300,   -24'sd1000, 24'sd200,   -24'sd1000, 24'd100},
    '{1'b0, KIND_OTHER,    22'd36,       24'sd200,   -24'sd1000, 24'sd200,   -24'sd900,  24'd100},
    // full-range chords, far beyond any clamp
    '{1'b0, KIND_LINEAR,   22'd40,       24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'hFFFFFF},
    '{1'b0, KIND_LINEAR,   22'd41,       24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFF0, 24'd15},
    '{1'b0, KIND_LINEAR,   22'd42,       24'h7FFFF0, 24'h7FFFF0, 24'h800000, 24'h800000, 24'hFFFFFF},
    '{1'b0, KIND_END,      22'd43,       24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'd0}
  };

  // ---------------------------------------------------------------------------
  // result channel: ready with random stalls, one nonblocking update per edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      fail_cnt++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // every result transaction is matched against the oldest owed result
  always @(posedge clk_i) begin
    kept_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (kept_due.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result, expected none, actual tag %h kind %h",
                 $time, out_tag_o, out_kind_o);
      end else begin
        want = kept_due.pop_front();
        check_field("out_tag",     want.tag,    out_tag_o);
        check_field("out_kind",    want.kind,   out_kind_o);
        check_field("out_end_x",   want.ex,     $unsigned(out_end_x_o));
        check_field("out_end_y",   want.ey,     $unsigned(out_end_y_o));
        check_field("joined",      want.joined, joined_o);
        check_field("last_of_run", want.last,   last_of_run_o);
      end
    end
  end

  // watchdog: far above the slowest correct run
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence: reset, directed rows, then config phases with random runs
  // ---------------------------------------------------------------------------
  initial begin
    seg_t s;
    logic [MIN_BITS-1:0] phase_min [NUM_CFG_PHASES];
    // cap, zero, above cap, tiny, anything, back to the reset value
    phase_min = '{10'd1000, 10'd0, 10'd1023, 10'd37,
                  MIN_BITS'($urandom_range(999, 1)), MIN_LEN_RST};

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part runs back to back with no idling
    foreach (directed_rows[i]) begin
      s.kind = directed_rows[i].kind;
      s.tag  = directed_rows[i].tag;
      s.sx   = directed_rows[i].sx;
      s.sy   = directed_rows[i].sy;
      s.ex   = directed_rows[i].ex;
      s.ey   = directed_rows[i].ey;
      s.len  = directed_rows[i].len;
      send_segment(s, directed_rows[i].thru);
    end
    drain_block();

    // the register is only rewritten while the block is empty;
    // group state carries over from one phase to the next
    for (int p = 0; p < NUM_CFG_PHASES; p++) begin
      write_min_length(phase_min[p]);
      case (p % 4)
        0: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        1: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        2: begin send_idle_pct = 22; recv_stall_pct = 22; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      repeat (ITEMS_PER_PHASE) begin
        make_segment(s);
        send_segment(s, 1'b0);
      end
      drain_block();
    end

    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/msl_pkg.sv
hw/rtl/msl_chord.sv
hw/rtl/msl_core.sv
hw/rtl/msl_outq.sv
hw/rtl/merge_short_line_segments_top.sv
dv/merge_short_line_segments_top_tb.sv
